@@ sv/assert_macros.svh @@
// Assertion macros used by the register block top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

@@ sv/gbrf_pkg.sv @@
// Types and constants of the GPIO bank register block.
package gbrf_pkg;

   localparam logic [31:0] ENABLE_ADDR = 32'h01E2_6008;
   localparam logic [31:0] WINDOW_BASE = 32'h01E2_6010;
   localparam int          PAIR_STRIDE = 40;

   typedef enum logic [1:0] {
      OPC_READ  = 2'd0,
      OPC_WRITE = 2'd1,
      OPC_PIN   = 2'd2,
      OPC_NONE  = 2'd3
   } opc_type;

   // word index within a bank pair
   typedef enum logic [3:0] {
      OFF_DIR  = 4'd0,
      OFF_OUT  = 4'd1,
      OFF_OSET = 4'd2,
      OFF_OCLR = 4'd3,
      OFF_DIN  = 4'd4,
      OFF_RSET = 4'd5,
      OFF_RCLR = 4'd6,
      OFF_FSET = 4'd7,
      OFF_FCLR = 4'd8,
      OFF_STAT = 4'd9
   } offs_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_RD_EN,
      ACT_RD_DIR,
      ACT_RD_OUT,
      ACT_RD_DIN,
      ACT_RD_RISE,
      ACT_RD_FALL,
      ACT_WR_EN,
      ACT_WR_DIR,
      ACT_WR_OUT,
      ACT_SET_OUT,
      ACT_CLR_OUT,
      ACT_SET_RISE,
      ACT_CLR_RISE,
      ACT_SET_FALL,
      ACT_CLR_FALL,
      ACT_PIN_SET,
      ACT_PIN_CLR
   } act_type;

   // decoded beat carried into the modify stage
   typedef struct packed {
      logic        ok;
      act_type     act;
      logic [31:0] data;
   } cmd_type;

   // one memory word holds every register of a bank pair
   typedef struct packed {
      logic [31:0] dir;
      logic [31:0] outl;
      logic [31:0] pins;
      logic [31:0] rise;
      logic [31:0] fall;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      dir:  32'hFFFF_FFFF,
      outl: 32'h0,
      pins: 32'h0,
      rise: 32'h0,
      fall: 32'h0
   };

endpackage

@@ sv/gbrf_decode.sv @@
// Address, size and pin-event decode of an incoming request beat.
module gbrf_decode #(
   parameter int BANK_PAIRS = 4,
   parameter int AW         = 2
) (
   input  logic [1:0]       opcode,
   input  logic [31:0]      bus_address,
   input  logic [63:0]      write_data,
   input  logic [3:0]       access_size,
   input  logic             commit_write,
   input  logic [3:0]       bank_number,
   input  logic [4:0]       pin_number,
   input  logic             pin_level,
   output gbrf_pkg::cmd_type cmd,
   output logic [AW-1:0]    pair
);

   localparam logic [31:0] WINDOW_END =
      gbrf_pkg::WINDOW_BASE + 32'(BANK_PAIRS * gbrf_pkg::PAIR_STRIDE);
   localparam logic [4:0]  BANK_LIMIT = 5'(2 * BANK_PAIRS);

   logic              addr_en;
   logic              in_win;
   logic [7:0]        rel;
   logic [7:0]        off;
   logic [AW-1:0]     win_pair;
   gbrf_pkg::offs_type word;
   gbrf_pkg::act_type  wr_act;
   logic              wr_ok;

   assign addr_en = (bus_address == gbrf_pkg::ENABLE_ADDR);
   assign in_win  = (bus_address >= gbrf_pkg::WINDOW_BASE) && (bus_address < WINDOW_END) &&
                    (bus_address[1:0] == 2'b00);
   assign rel     = bus_address[7:0] - gbrf_pkg::WINDOW_BASE[7:0];

   // rel < 160, so pair and offset come from a few compares against the stride
   always_comb begin
      win_pair = '0;
      off      = rel;
      for (int k = 1; k < BANK_PAIRS; k++) begin
         if (rel >= 8'(k * gbrf_pkg::PAIR_STRIDE)) begin
            win_pair = AW'(k);
            off      = rel - 8'(k * gbrf_pkg::PAIR_STRIDE);
         end
      end
   end

   assign word = gbrf_pkg::offs_type'(off[5:2]);

   always_comb begin
      wr_ok  = 1'b1;
      wr_act = gbrf_pkg::ACT_NONE;
      case (word)
         gbrf_pkg::OFF_DIR:  wr_act = gbrf_pkg::ACT_WR_DIR;
         gbrf_pkg::OFF_OUT:  wr_act = gbrf_pkg::ACT_WR_OUT;
         gbrf_pkg::OFF_OSET: wr_act = gbrf_pkg::ACT_SET_OUT;
         gbrf_pkg::OFF_OCLR: wr_act = gbrf_pkg::ACT_CLR_OUT;
         gbrf_pkg::OFF_RSET: wr_act = gbrf_pkg::ACT_SET_RISE;
         gbrf_pkg::OFF_RCLR: wr_act = gbrf_pkg::ACT_CLR_RISE;
         gbrf_pkg::OFF_FSET: wr_act = gbrf_pkg::ACT_SET_FALL;
         gbrf_pkg::OFF_FCLR: wr_act = gbrf_pkg::ACT_CLR_FALL;
         default:            wr_ok  = 1'b0;
      endcase
   end

   always_comb begin
      cmd.ok   = 1'b0;
      cmd.act  = gbrf_pkg::ACT_NONE;
      cmd.data = write_data[31:0];
      pair     = win_pair;
      case (gbrf_pkg::opc_type'(opcode))
         gbrf_pkg::OPC_READ: begin
            if (addr_en) begin
               cmd.ok  = 1'b1;
               cmd.act = gbrf_pkg::ACT_RD_EN;
            end else if (in_win) begin
               cmd.ok = 1'b1;
               case (word)
                  gbrf_pkg::OFF_DIR:  cmd.act = gbrf_pkg::ACT_RD_DIR;
                  gbrf_pkg::OFF_OUT,
                  gbrf_pkg::OFF_OSET,
                  gbrf_pkg::OFF_OCLR: cmd.act = gbrf_pkg::ACT_RD_OUT;
                  gbrf_pkg::OFF_DIN:  cmd.act = gbrf_pkg::ACT_RD_DIN;
                  gbrf_pkg::OFF_RSET,
                  gbrf_pkg::OFF_RCLR: cmd.act = gbrf_pkg::ACT_RD_RISE;
                  gbrf_pkg::OFF_FSET,
                  gbrf_pkg::OFF_FCLR: cmd.act = gbrf_pkg::ACT_RD_FALL;
                  default:            cmd.ok  = 1'b0;
               endcase
            end
         end
         gbrf_pkg::OPC_WRITE: begin
            // size, then value width, then address
            if ((access_size == 4'd4) && (write_data[63:32] == 32'h0)) begin
               if (addr_en) begin
                  if (write_data[31:8] == 24'h0) begin
                     cmd.ok  = 1'b1;
                     cmd.act = commit_write ? gbrf_pkg::ACT_WR_EN : gbrf_pkg::ACT_NONE;
                  end
               end else if (in_win && wr_ok) begin
                  cmd.ok  = 1'b1;
                  cmd.act = commit_write ? wr_act : gbrf_pkg::ACT_NONE;
               end
            end
         end
         gbrf_pkg::OPC_PIN: begin
            pair = AW'(bank_number[3:1]);
            if (({1'b0, bank_number} < BANK_LIMIT) && !pin_number[4]) begin
               cmd.ok   = 1'b1;
               cmd.act  = pin_level ? gbrf_pkg::ACT_PIN_SET : gbrf_pkg::ACT_PIN_CLR;
               cmd.data = 32'h1 << {bank_number[0], pin_number[3:0]};
            end
         end
         default: begin
            cmd.ok = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/gbrf_mem.sv @@
// Bank-pair register memory: one write port, one registered read port.
module gbrf_mem #(
   parameter int DEPTH = 4,
   parameter int AW    = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output gbrf_pkg::entry_type rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  gbrf_pkg::entry_type wr_data
);

   gbrf_pkg::entry_type mem_ff [DEPTH];
   logic [DEPTH-1:0]    vld_ff;
   gbrf_pkg::entry_type rd_word_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   // entries never written read as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : gbrf_pkg::ENTRY_RESET;

endmodule

@@ sv/gbrf_modify.sv @@
// Read data selection and register update for one decoded beat.
module gbrf_modify (
   input  gbrf_pkg::cmd_type   cmd,
   input  gbrf_pkg::entry_type cur,
   input  logic [7:0]          irq_en,
   output gbrf_pkg::entry_type nxt,
   output logic                wr_en,
   output logic                irq_we,
   output logic [31:0]         read_data
);

   always_comb begin
      nxt       = cur;
      wr_en     = 1'b0;
      irq_we    = 1'b0;
      read_data = 32'h0;
      case (cmd.act)
         gbrf_pkg::ACT_RD_EN:   read_data = {24'h0, irq_en};
         gbrf_pkg::ACT_RD_DIR:  read_data = cur.dir;
         gbrf_pkg::ACT_RD_OUT:  read_data = cur.outl;
         gbrf_pkg::ACT_RD_DIN:  read_data = (cur.outl & ~cur.dir) | (cur.pins & cur.dir);
         gbrf_pkg::ACT_RD_RISE: read_data = cur.rise;
         gbrf_pkg::ACT_RD_FALL: read_data = cur.fall;
         gbrf_pkg::ACT_WR_EN:   irq_we    = 1'b1;
         gbrf_pkg::ACT_WR_DIR: begin
            nxt.dir = cmd.data;
            wr_en   = 1'b1;
         end
         gbrf_pkg::ACT_WR_OUT: begin
            nxt.outl = cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_SET_OUT: begin
            nxt.outl = cur.outl | cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_CLR_OUT: begin
            nxt.outl = cur.outl & ~cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_SET_RISE: begin
            nxt.rise = cur.rise | cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_CLR_RISE: begin
            nxt.rise = cur.rise & ~cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_SET_FALL: begin
            nxt.fall = cur.fall | cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_CLR_FALL: begin
            nxt.fall = cur.fall & ~cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_PIN_SET: begin
            nxt.pins = cur.pins | cmd.data;
            wr_en    = 1'b1;
         end
         gbrf_pkg::ACT_PIN_CLR: begin
            nxt.pins = cur.pins & ~cmd.data;
            wr_en    = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/gpio_bank_register_file_top.sv @@
// Top level of the GPIO bank register block.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | opcode, address, data, size, commit, pin event
//   rsp     | out       | rsp_valid/rsp_stall | accepted, read_data
//
// One beat per cycle sustained while rsp_stall is low. A req beat is decoded and its
// bank-pair word read from the memory at the accept edge; the modify stage then modifies
// and writes it back and loads the response register once that register is free.
// A write followed at once by a beat to the same pair is forwarded around the memory.
// Reset clears the pipeline valids, memory valid bits and the interrupt enable.
// rsp_stall holds the response register; req_stall rises only while both it and the
// modify stage are occupied.
`include "assert_macros.svh"

module gpio_bank_register_file_top #(
   parameter int BANK_PAIRS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_bus_address,
   input  logic [63:0] req_write_data,
   input  logic [3:0]  req_access_size,
   input  logic        req_commit_write,
   input  logic [3:0]  req_bank_number,
   input  logic [4:0]  req_pin_number,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [31:0] rsp_read_data
);

   localparam int AW = (BANK_PAIRS > 1) ? $clog2(BANK_PAIRS) : 1;

   gbrf_pkg::cmd_type   dec_cmd;
   logic [AW-1:0]       dec_pair;
   logic                req_fire;
   logic                out_free;
   logic                s1_fire;

   logic                s1_valid_ff;
   gbrf_pkg::cmd_type   s1_cmd_ff;
   logic [AW-1:0]       s1_pair_ff;
   logic                byp_ff;
   gbrf_pkg::entry_type byp_data_ff;
   logic [7:0]          irq_en_ff;

   gbrf_pkg::entry_type mem_rd_data;
   gbrf_pkg::entry_type cur_entry;
   gbrf_pkg::entry_type nxt_entry;
   logic                mod_wr_en;
   logic                mod_irq_we;
   logic [31:0]         mod_read_data;
   logic                mem_wr_en;

   logic                rsp_valid_ff;
   logic                rsp_accepted_ff;
   logic [31:0]         rsp_read_data_ff;

   gbrf_decode #(
      .BANK_PAIRS (BANK_PAIRS),
      .AW         (AW)
   ) u_decode (
      .opcode       (req_opcode),
      .bus_address  (req_bus_address),
      .write_data   (req_write_data),
      .access_size  (req_access_size),
      .commit_write (req_commit_write),
      .bank_number  (req_bank_number),
      .pin_number   (req_pin_number),
      .pin_level    (req_pin_level),
      .cmd          (dec_cmd),
      .pair         (dec_pair)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign mem_wr_en = s1_fire && mod_wr_en;

   gbrf_mem #(
      .DEPTH (BANK_PAIRS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (dec_pair),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_pair_ff),
      .wr_data (nxt_entry)
   );

   // the memory read at the write edge saw the old word
   assign cur_entry = byp_ff ? byp_data_ff : mem_rd_data;

   gbrf_modify u_modify (
      .cmd       (s1_cmd_ff),
      .cur       (cur_entry),
      .irq_en    (irq_en_ff),
      .nxt       (nxt_entry),
      .wr_en     (mod_wr_en),
      .irq_we    (mod_irq_we),
      .read_data (mod_read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         irq_en_ff    <= 8'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            byp_ff      <= mem_wr_en && (s1_pair_ff == dec_pair);
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
            byp_ff      <= 1'b0;
         end
         if (s1_fire && mod_irq_we) begin
            irq_en_ff <= s1_cmd_ff.data[7:0];
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= dec_cmd;
         s1_pair_ff <= dec_pair;
      end
      if (mem_wr_en) begin
         byp_data_ff <= nxt_entry;
      end
      if (s1_fire) begin
         rsp_accepted_ff  <= s1_cmd_ff.ok;
         rsp_read_data_ff <= mod_read_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_read_data = rsp_read_data_ff;

   `ASSERT_CLK(a_byp_has_beat, clock, reset, byp_ff |-> s1_valid_ff, "forward flag without beat")
   `ASSERT_CLK(a_reject_zero, clock, reset, (rsp_valid && !rsp_accepted) |-> (rsp_read_data == 32'h0), "rejected beat carries data")
   `ASSERT_CLK(a_s1_to_rsp, clock, reset, s1_fire |=> rsp_valid, "modify stage beat lost")
   `ASSERT_NEVER(a_reject_writes, clock, reset, s1_fire && !s1_cmd_ff.ok && (mod_wr_en || mod_irq_we), "rejected beat updates state")

endmodule

@@ sim/gpio_regs_monitor.sv @@
`timescale 1ns / 1ps
// Watches both channels of the GPIO bank register block, predicts each response and checks it.
module gpio_regs_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_bus_address,
   input  logic [63:0] req_write_data,
   input  logic [3:0]  req_access_size,
   input  logic        req_commit_write,
   input  logic [3:0]  req_bank_number,
   input  logic [4:0]  req_pin_number,
   input  logic        req_pin_level,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_accepted,
   input  logic [31:0] rsp_read_data,
   output int          error_count,
   output int          pending_count,
   output int          taken_count,
   output int          refused_count
);
   localparam int PAIRS = 4;
   localparam int BANKS = 2 * PAIRS;
   localparam logic [31:0] WINDOW_LIMIT =
      gbrf_pkg::WINDOW_BASE + PAIRS * gbrf_pkg::PAIR_STRIDE;

   typedef struct packed {
      logic        accepted;
      logic [31:0] read_data;
   } reply_type;

   logic [31:0] dir_q   [PAIRS];
   logic [31:0] out_q   [PAIRS];
   logic [31:0] pins_q  [PAIRS];
   logic [31:0] rise_q  [PAIRS];
   logic [31:0] fall_q  [PAIRS];
   logic [7:0]  irq_en_q;
   reply_type   pending_replies[$];

   function automatic logic locate(input logic [31:0] addr, output int pair,
                                   output gbrf_pkg::offs_type word);
      logic [31:0] rel;
      rel  = addr - gbrf_pkg::WINDOW_BASE;
      pair = rel / gbrf_pkg::PAIR_STRIDE;
      word = gbrf_pkg::offs_type'(4'((rel % gbrf_pkg::PAIR_STRIDE) >> 2));
      return addr >= gbrf_pkg::WINDOW_BASE && addr < WINDOW_LIMIT && addr[1:0] == 2'b00;
   endfunction

   // applies one request beat to the shadow registers and returns its response
   function automatic reply_type gpio_access_outcome(
      input gbrf_pkg::opc_type op, input logic [31:0] addr, input logic [63:0] wdata,
      input logic [3:0] size, input logic commit, input logic [3:0] bank,
      input logic [4:0] pin, input logic level);
      reply_type          r;
      int                 pair;
      int                 bitpos;
      gbrf_pkg::offs_type word;
      logic               hit;
      logic [31:0]        v;
      r   = '0;
      v   = wdata[31:0];
      hit = locate(addr, pair, word);
      case (op)
         gbrf_pkg::OPC_READ: begin
            if (addr == gbrf_pkg::ENABLE_ADDR) begin
               r.accepted  = 1'b1;
               r.read_data = {24'h0, irq_en_q};
            end else if (hit) begin
               r.accepted = 1'b1;
               case (word)
                  gbrf_pkg::OFF_DIR: r.read_data = dir_q[pair];
                  gbrf_pkg::OFF_OUT, gbrf_pkg::OFF_OSET, gbrf_pkg::OFF_OCLR:
                     r.read_data = out_q[pair];
                  // output pins show the latch, input pins the pin level
                  gbrf_pkg::OFF_DIN: r.read_data = (out_q[pair] & ~dir_q[pair]) |
                                                   (pins_q[pair] & dir_q[pair]);
                  gbrf_pkg::OFF_RSET, gbrf_pkg::OFF_RCLR: r.read_data = rise_q[pair];
                  gbrf_pkg::OFF_FSET, gbrf_pkg::OFF_FCLR: r.read_data = fall_q[pair];
                  default:                                r.accepted = 1'b0;
               endcase
            end
         end
         gbrf_pkg::OPC_WRITE: begin
            // size and width are checked ahead of the address
            if (size == 4'd4 && wdata[63:32] == '0) begin
               if (addr == gbrf_pkg::ENABLE_ADDR) begin
                  r.accepted = (v[31:8] == '0);
                  if (r.accepted && commit)
                     irq_en_q = v[7:0];
               end else if (hit && word != gbrf_pkg::OFF_DIN &&
                            word != gbrf_pkg::OFF_STAT) begin
                  r.accepted = 1'b1;
                  if (commit) begin
                     case (word)
                        gbrf_pkg::OFF_DIR:  dir_q[pair]  = v;
                        gbrf_pkg::OFF_OUT:  out_q[pair]  = v;
                        gbrf_pkg::OFF_OSET: out_q[pair]  = out_q[pair] | v;
                        gbrf_pkg::OFF_OCLR: out_q[pair]  = out_q[pair] & ~v;
                        gbrf_pkg::OFF_RSET: rise_q[pair] = rise_q[pair] | v;
                        gbrf_pkg::OFF_RCLR: rise_q[pair] = rise_q[pair] & ~v;
                        gbrf_pkg::OFF_FSET: fall_q[pair] = fall_q[pair] | v;
                        gbrf_pkg::OFF_FCLR: fall_q[pair] = fall_q[pair] & ~v;
                        default: ;
                     endcase
                  end
               end
            end
         end
         gbrf_pkg::OPC_PIN: begin
            if (bank < BANKS && pin < 5'd16) begin
               r.accepted = 1'b1;
               bitpos = pin + (bank[0] ? 16 : 0);
               pins_q[bank[2:1]][bitpos] = level;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < PAIRS; i++) begin
            dir_q[i]  = '1;
            out_q[i]  = '0;
            pins_q[i] = '0;
            rise_q[i] = '0;
            fall_q[i] = '0;
         end
         irq_en_q = '0;
         pending_replies.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_replies.push_back(gpio_access_outcome(
               gbrf_pkg::opc_type'(req_opcode), req_bus_address, req_write_data,
               req_access_size, req_commit_write, req_bank_number, req_pin_number,
               req_pin_level));
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               error_count++;
               $display("%0t: rsp beat with nothing expected, actual accepted %b read_data %h",
                        $time, rsp_accepted, rsp_read_data);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  error_count++;
                  $display("%0t: accepted mismatch, expected %b actual %b",
                           $time, want.accepted, rsp_accepted);
               end
               if (rsp_read_data !== want.read_data) begin
                  error_count++;
                  $display("%0t: read_data mismatch, expected %h actual %h",
                           $time, want.read_data, rsp_read_data);
               end
               if (want.accepted)
                  taken_count++;
               else
                  refused_count++;
            end
         end
      end
      pending_count = pending_replies.size();
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Stimulus, clock, reset, watchdog and verdict for the GPIO bank register block.
module tb_top;

   localparam int RANDOM_BEATS = 1850;
   localparam int MAX_WAIT     = 12;
   localparam int IDLE_LIMIT   = 400;
   localparam logic [31:0] WINDOW_LIMIT = gbrf_pkg::WINDOW_BASE + 4 * gbrf_pkg::PAIR_STRIDE;

   typedef struct {
      gbrf_pkg::opc_type op;
      logic [31:0]       addr;
      logic [63:0]       wdata;
      logic [3:0]        size;
      logic              commit;
      logic [3:0]        bank;
      logic [4:0]        pin;
      logic              level;
   } gpio_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [31:0] req_bus_address;
   logic [63:0] req_write_data;
   logic [3:0]  req_access_size;
   logic        req_commit_write;
   logic [3:0]  req_bank_number;
   logic [4:0]  req_pin_number;
   logic        req_pin_level;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_accepted;
   logic [31:0] rsp_read_data;

   int error_count;
   int pending_count;
   int taken_count;
   int refused_count;
   int read_beats;
   int write_beats;
   int pin_beats;
   int bad_op_beats;
   int idle_cycles;
   bit calm;

   gpio_bank_register_file_top dut (.*);

   gpio_regs_monitor u_monitor (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_wait();
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [31:0] reg_addr(input int pair, input gbrf_pkg::offs_type word);
      return gbrf_pkg::WINDOW_BASE + pair * gbrf_pkg::PAIR_STRIDE + 4 * word;
   endfunction

   function automatic gpio_req_type read_req(input logic [31:0] addr);
      gpio_req_type r;
      r = '{gbrf_pkg::OPC_READ, addr, 64'h0, 4'd0, 1'b0, 4'd0, 5'd0, 1'b0};
      return r;
   endfunction

   function automatic gpio_req_type write_req(input logic [31:0] addr,
                                              input logic [63:0] data,
                                              input logic [3:0] size = 4'd4,
                                              input logic commit = 1'b1);
      gpio_req_type r;
      r = '{gbrf_pkg::OPC_WRITE, addr, data, size, commit, 4'd0, 5'd0, 1'b0};
      return r;
   endfunction

   function automatic gpio_req_type pin_req(input logic [3:0] bank, input logic [4:0] pin,
                                            input logic level);
      gpio_req_type r;
      r = '{gbrf_pkg::OPC_PIN, 32'h0, 64'h0, 4'd0, 1'b0, bank, pin, level};
      return r;
   endfunction

   // mostly well-formed register traffic, the rest noise around and away from the window
   function automatic gpio_req_type random_request();
      gpio_req_type r;
      int kind;
      int word;
      r.op     = gbrf_pkg::opc_type'(2'($urandom_range(0, 3)));
      r.addr   = $urandom();
      r.wdata  = {$urandom(), $urandom()};
      r.size   = 4'($urandom_range(0, 15));
      r.commit = 1'($urandom_range(0, 1));
      r.bank   = 4'($urandom_range(0, 15));
      r.pin    = 5'($urandom_range(0, 31));
      r.level  = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
         word   = $urandom_range(0, 10);
         r.addr = (word == 10) ? gbrf_pkg::ENABLE_ADDR :
                  reg_addr($urandom_range(0, 3), gbrf_pkg::offs_type'(4'(word)));
      end else if (kind < 94) begin
         r.addr = gbrf_pkg::WINDOW_BASE - 32'd8 + $urandom_range(0, 180);
      end
      if (kind < 40) begin
         r.op = gbrf_pkg::OPC_READ;
      end else if (kind < 75) begin
         r.op = gbrf_pkg::OPC_WRITE;
         if ($urandom_range(0, 9) != 0)
            r.size = 4'd4;
         if ($urandom_range(0, 9) != 0)
            r.wdata[63:32] = '0;
         if ($urandom_range(0, 9) != 0)
            r.commit = 1'b1;
         if (r.addr == gbrf_pkg::ENABLE_ADDR && $urandom_range(0, 3) != 0)
            r.wdata[31:8] = '0;
      end else if (kind < 88) begin
         r.op = gbrf_pkg::OPC_PIN;
         if ($urandom_range(0, 9) != 0) begin
            r.bank[3] = 1'b0;
            r.pin[4]  = 1'b0;
         end
      end
      return r;
   endfunction

   task automatic issue(input gpio_req_type r);
      int gap;
      gap = pick_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= r.op;
      req_bus_address  <= r.addr;
      req_write_data   <= r.wdata;
      req_access_size  <= r.size;
      req_commit_write <= r.commit;
      req_bank_number  <= r.bank;
      req_pin_number   <= r.pin;
      req_pin_level    <= r.level;
      case (r.op)
         gbrf_pkg::OPC_READ:  read_beats++;
         gbrf_pkg::OPC_WRITE: write_beats++;
         gbrf_pkg::OPC_PIN:   pin_beats++;
         default:             bad_op_beats++;
      endcase
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // response side: random stall before each beat
   initial begin
      int hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold = pick_wait();
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      gpio_req_type r;
      reset            = 1'b1;
      calm             = 1'b0;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_bus_address  = '0;
      req_write_data   = '0;
      req_access_size  = '0;
      req_commit_write = 1'b0;
      req_bank_number  = '0;
      req_pin_number   = '0;
      req_pin_level    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue(read_req(gbrf_pkg::ENABLE_ADDR));
      issue(read_req(reg_addr(0, gbrf_pkg::OFF_DIR)));
      issue(write_req(reg_addr(0, gbrf_pkg::OFF_DIR), 64'h0000_FFFF));
      issue(write_req(reg_addr(0, gbrf_pkg::OFF_OUT), 64'hFFFF_FFFF));
      issue(write_req(reg_addr(0, gbrf_pkg::OFF_OCLR), 64'h0000_00F0));
      issue(write_req(reg_addr(0, gbrf_pkg::OFF_OSET), 64'h0001_0000));
      issue(pin_req(4'd0, 5'd0, 1'b1));
      issue(pin_req(4'd7, 5'd15, 1'b1));
      issue(read_req(reg_addr(0, gbrf_pkg::OFF_DIN)));
      issue(read_req(reg_addr(3, gbrf_pkg::OFF_DIN)));
      issue(write_req(reg_addr(2, gbrf_pkg::OFF_RSET), 64'hFFFF_FFFF));
      issue(write_req(reg_addr(2, gbrf_pkg::OFF_RCLR), 64'h0000_FFFF));
      issue(write_req(reg_addr(3, gbrf_pkg::OFF_FSET), 64'hA5A5_A5A5));
      issue(write_req(reg_addr(3, gbrf_pkg::OFF_FCLR), 64'h0000_0005));
      issue(read_req(reg_addr(2, gbrf_pkg::OFF_RCLR)));
      issue(read_req(reg_addr(3, gbrf_pkg::OFF_FSET)));
      issue(write_req(gbrf_pkg::ENABLE_ADDR, 64'h0000_00FF));
      issue(write_req(gbrf_pkg::ENABLE_ADDR, 64'h0000_0100));
      issue(write_req(reg_addr(1, gbrf_pkg::OFF_DIN), 64'h1));
      issue(read_req(reg_addr(1, gbrf_pkg::OFF_STAT)));
      issue(write_req(reg_addr(1, gbrf_pkg::OFF_STAT), 64'h1));
      issue(write_req(reg_addr(1, gbrf_pkg::OFF_DIR), 64'h1, 4'd8));
      issue(write_req(reg_addr(1, gbrf_pkg::OFF_DIR), 64'h1_0000_0000));
      issue(write_req(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
      issue(write_req(reg_addr(1, gbrf_pkg::OFF_OUT), 64'h1234_5678, 4'd4, 1'b0));
      issue(read_req(reg_addr(1, gbrf_pkg::OFF_OUT)));
      issue(read_req(gbrf_pkg::WINDOW_BASE + 32'd2));
      issue(read_req(WINDOW_LIMIT));
      issue(pin_req(4'd8, 5'd0, 1'b1));
      issue(pin_req(4'd7, 5'd16, 1'b1));
      r    = read_req(gbrf_pkg::ENABLE_ADDR);
      r.op = gbrf_pkg::OPC_NONE;
      issue(r);
      wait_for_replies();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (n % 400 == 399)
            wait_for_replies();
         issue(random_request());
      end
      wait_for_replies();
      repeat (10) @(posedge clock);

      $display("Sent %0d reads, %0d writes, %0d pin events, %0d unknown opcodes.",
               read_beats, write_beats, pin_beats, bad_op_beats);
      $display("Responses seen: %0d accepted, %0d rejected; %0d mismatches.",
               taken_count, refused_count, error_count);
      if (error_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
